### rtl/core/dgml_pkg.sv
// types, constants and the light-level mapping for the dark-gated motion light timer
// no dependencies; imported by dark_gated_motion_light_timer_top

package dgml_pkg;

  typedef enum logic [1:0] {
    KIND_SAMPLE_TICK = 2'd0,
    KIND_ADC_RESULT  = 2'd1,
    KIND_MOTION_EDGE = 2'd2,
    KIND_LAMP_TICK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_DARK_THRESHOLD      = 2'd0,
    CFG_ON_TIME_TICKS       = 2'd1,
    CFG_SAMPLE_PERIOD_TICKS = 2'd2,
    CFG_INDICATOR_OFF_TICK  = 2'd3
  } cfg_index_t;

  typedef struct packed {
    kind_t       kind;
    logic [9:0]  adc_code;
  } in_word_t;

  typedef struct packed {
    logic        motion_lamp;
    logic        dark_lamp;
    logic        conversion_lamp;
    logic        start_conversion;
    logic [7:0]  light_level;
  } out_word_t;

  localparam logic [7:0] DARK_THRESHOLD_RST      = 8'd20;
  localparam logic [7:0] ON_TIME_TICKS_RST       = 8'd130;
  localparam logic [4:0] SAMPLE_PERIOD_TICKS_RST = 5'd25;
  localparam logic [4:0] INDICATOR_OFF_TICK_RST  = 5'd6;
  localparam logic [7:0] LEVEL_RST               = 8'd100;

  localparam int NUM_BANDS = 6;

  // band limits in converter codes, slope in q20 (applied to code x5), offset in q10
  localparam logic [9:0] BAND_LO [NUM_BANDS] = '{
    10'd306, 10'd570, 10'd691, 10'd781, 10'd830, 10'd871};
  localparam logic [9:0] BAND_HI [NUM_BANDS] = '{
    10'd569, 10'd690, 10'd780, 10'd829, 10'd870, 10'd888};
  localparam logic [18:0] BAND_SLOPE [NUM_BANDS] = '{
    19'd15391, 19'd38400, 19'd73728, 19'd132506, 19'd212378, 19'd315392};
  localparam logic [20:0] BAND_OFFSET [NUM_BANDS] = '{
    21'd17971, 21'd83507, 21'd204902, 21'd429670, 21'd754381, 21'd1193984};

  // piecewise linear code to level; a code outside every band keeps old_level
  function automatic logic [7:0] map_level(input logic [9:0] code,
                                           input logic [7:0] old_level);
    logic        hit;
    logic [18:0] slope;
    logic [20:0] offset;
    logic [12:0] code_x5;
    logic [31:0] prod;
    logic [21:0] prod_q10;
    logic [21:0] diff;
    logic [11:0] lvl;
    logic [7:0]  result;
    hit    = 1'b0;
    slope  = '0;
    offset = '0;
    for (int i = 0; i < NUM_BANDS; i++) begin
      if (code >= BAND_LO[i] && code <= BAND_HI[i]) begin
        hit    = 1'b1;
        slope  = BAND_SLOPE[i];
        offset = BAND_OFFSET[i];
      end
    end
    code_x5  = {1'b0, code, 2'b00} + {3'b000, code};
    prod     = {19'd0, code_x5} * {13'd0, slope};
    prod_q10 = prod[31:10];
    if (prod_q10 <= {1'b0, offset}) begin
      diff = '0;
    end else begin
      diff = prod_q10 - {1'b0, offset};
    end
    lvl = diff[21:10];
    if (lvl > 12'd255) begin
      result = 8'd255;
    end else begin
      result = lvl[7:0];
    end
    if (hit) begin
      return result;
    end
    return old_level;
  endfunction

endpackage

### rtl/core/dark_gated_motion_light_timer_top.sv
// dark-gated motion light timer: event decode, light-level mapping, lamp timers
// depends on dgml_pkg

// Takes one event word per cycle (sample tick, converter result, motion edge or
// lamp tick) and returns exactly one output word per event with the lamp states,
// the conversion-start pulse and the current light level. The state registers
// and the output register load together at the accepting edge, and the output
// word is valid in the cycle after the event was taken. Input stall is asserted
// only while an output word is held by a stalled receiver, so while the receiver
// does not stall the sustained rate is one event per clock. The level mapping uses
// one 13x19 multiplier selected per band. Configuration writes are
// always ready and take effect on the next event.

module dark_gated_motion_light_timer_top
  import dgml_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_index_t  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] dark_threshold;
  logic [7:0] on_time_ticks;
  logic [4:0] sample_period_ticks;
  logic [4:0] indicator_off_tick;

  logic [7:0] level_reg, level_reg_next;
  logic       dark_flag, dark_flag_next;
  logic [4:0] sample_count, sample_count_next;
  logic [7:0] on_count, on_count_next;
  logic       on_timer_running, on_timer_running_next;
  logic       motion_lamp_reg, motion_lamp_reg_next;
  logic       conversion_lamp_reg, conversion_lamp_reg_next;
  logic       start_next;

  logic       accept;
  logic [4:0] sample_inc;
  logic [7:0] on_inc;
  logic [7:0] mapped_level;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dark_threshold      <= DARK_THRESHOLD_RST;
      on_time_ticks       <= ON_TIME_TICKS_RST;
      sample_period_ticks <= SAMPLE_PERIOD_TICKS_RST;
      indicator_off_tick  <= INDICATOR_OFF_TICK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DARK_THRESHOLD:      dark_threshold      <= cfg_data;
        CFG_ON_TIME_TICKS:       on_time_ticks       <= cfg_data;
        CFG_SAMPLE_PERIOD_TICKS: sample_period_ticks <= cfg_data[4:0];
        CFG_INDICATOR_OFF_TICK:  indicator_off_tick  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign sample_inc   = sample_count + 5'd1;
  assign on_inc       = on_count + 8'd1;
  assign mapped_level = map_level(in_word.adc_code, level_reg);

  always_comb begin
    level_reg_next           = level_reg;
    dark_flag_next           = dark_flag;
    sample_count_next        = sample_count;
    on_count_next            = on_count;
    on_timer_running_next    = on_timer_running;
    motion_lamp_reg_next     = motion_lamp_reg;
    conversion_lamp_reg_next = conversion_lamp_reg;
    start_next               = 1'b0;
    unique case (in_word.kind)
      KIND_SAMPLE_TICK: begin
        sample_count_next = sample_inc;
        // indicator-off match wins over the period wrap
        if (sample_inc == indicator_off_tick) begin
          conversion_lamp_reg_next = 1'b0;
        end else if (sample_inc == sample_period_ticks) begin
          sample_count_next = '0;
          start_next        = 1'b1;
        end
      end
      KIND_ADC_RESULT: begin
        conversion_lamp_reg_next = 1'b1;
        level_reg_next           = mapped_level;
        if (mapped_level < dark_threshold) begin
          dark_flag_next = 1'b1;
        end else begin
          dark_flag_next       = 1'b0;
          motion_lamp_reg_next = 1'b0;
        end
      end
      KIND_MOTION_EDGE: begin
        if (dark_flag) begin
          on_count_next         = '0;
          motion_lamp_reg_next  = 1'b1;
          on_timer_running_next = 1'b1;
        end
      end
      KIND_LAMP_TICK: begin
        if (on_timer_running) begin
          on_count_next = on_inc;
          if (on_inc == on_time_ticks) begin
            on_count_next            = '0;
            motion_lamp_reg_next     = 1'b0;
            conversion_lamp_reg_next = 1'b0;
            on_timer_running_next    = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_reg           <= LEVEL_RST;
      dark_flag           <= 1'b0;
      sample_count        <= '0;
      on_count            <= '0;
      on_timer_running    <= 1'b0;
      motion_lamp_reg     <= 1'b0;
      conversion_lamp_reg <= 1'b0;
    end else if (accept) begin
      level_reg           <= level_reg_next;
      dark_flag           <= dark_flag_next;
      sample_count        <= sample_count_next;
      on_count            <= on_count_next;
      on_timer_running    <= on_timer_running_next;
      motion_lamp_reg     <= motion_lamp_reg_next;
      conversion_lamp_reg <= conversion_lamp_reg_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= accept | (out_valid & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word.motion_lamp      <= motion_lamp_reg_next;
      out_word.dark_lamp        <= dark_flag_next;
      out_word.conversion_lamp  <= conversion_lamp_reg_next;
      out_word.start_conversion <= start_next;
      out_word.light_level      <= level_reg_next;
    end
  end

`ifndef SYNTHESIS
  a_motion_needs_timer: assert property (@(posedge clk) disable iff (rst)
    motion_lamp_reg |-> on_timer_running)
    else $error("motion lamp on with on-timer stopped");

  a_start_only_on_sample: assert property (@(posedge clk) disable iff (rst)
    accept && in_word.kind != KIND_SAMPLE_TICK |=> !out_word.start_conversion)
    else $error("conversion start on a non-sample event");

  a_adc_lights_lamp: assert property (@(posedge clk) disable iff (rst)
    accept && in_word.kind == KIND_ADC_RESULT |=> conversion_lamp_reg
      && out_word.conversion_lamp)
    else $error("converter result did not light conversion lamp");

  a_motion_restart: assert property (@(posedge clk) disable iff (rst)
    accept && in_word.kind == KIND_MOTION_EDGE && dark_flag |=>
      motion_lamp_reg && on_timer_running && on_count == 8'd0)
    else $error("motion while dark did not restart on-timer");

  a_out_matches_state: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_word.dark_lamp == dark_flag && out_word.light_level == level_reg)
    else $error("output word does not match state");
`endif

endmodule
